FILE: src/rpsb_pkg.sv
// Shared types, codes and widths for the rotated palette sprite blitter.
package rpsb_pkg;

   // default geometry
   localparam int SCREEN_WIDTH_DEF    = 320;
   localparam int SCREEN_HEIGHT_DEF   = 240;
   localparam int MAX_SPRITE_SIZE_DEF = 32;
   localparam int PALETTE_ENTRIES_DEF = 256;

   // field and bus widths
   localparam int FUNC_W      = 2;
   localparam int LOAD_IDX_W  = 10;
   localparam int VALUE_W     = 16;
   localparam int ORIGIN_W    = 16;
   localparam int CELL_W      = 5;
   localparam int SIZE_W      = 6;
   localparam int ROT_W       = 2;
   localparam int FB_ADDR_W   = 17;
   localparam int COLOR_W     = 16;
   localparam int BYTE_W      = 8;
   localparam int PIX_W       = 8;
   localparam int COORD_W     = 17;  // origin plus cell, signed
   localparam int SRC_IDX_W   = 12;  // covers the largest sprite store
   localparam int PAL_IDX_W   = 8;   // covers the largest palette
   localparam int REQ_DATA_W  = 80;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 9;
   localparam logic [PIX_W-1:0] TRANSPARENT_INDEX = '0;

   // transaction kinds
   localparam logic [FUNC_W-1:0] FUNC_LOAD_PALETTE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_SPRITE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DRAW         = 2'd2;

   // rotations
   localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
   localparam logic [ROT_W-1:0] ROT_90   = 2'd1;
   localparam logic [ROT_W-1:0] ROT_180  = 2'd2;
   localparam logic [ROT_W-1:0] ROT_270  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_LEFT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_TOP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_RIGHT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_BOTTOM = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_BYTES  = 3'd4;

   localparam logic [8:0] CLIP_LEFT_RESET   = 9'd0;
   localparam logic [7:0] CLIP_TOP_RESET    = 8'd0;
   localparam logic [8:0] CLIP_RIGHT_RESET  = 9'd320;
   localparam logic [7:0] CLIP_BOTTOM_RESET = 8'd240;

   // first pipeline stage contents
   typedef struct packed {
      logic                        draw_ok;
      logic                        spr_we;
      logic                        pal_we;
      logic [SRC_IDX_W-1:0]        mem_idx;
      logic [PAL_IDX_W-1:0]        pal_idx;
      logic [VALUE_W-1:0]          value;
      logic signed [COORD_W-1:0]   dx;
      logic signed [COORD_W-1:0]   dy;
   } front_type;

endpackage

FILE: src/rpsb_front.sv
// First pipeline stage: decode, sprite geometry checks, rotated source index, screen coordinates.
module rpsb_front import rpsb_pkg::*; #(
   parameter int MAX_SPRITE_SIZE = MAX_SPRITE_SIZE_DEF,
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic [FUNC_W-1:0]          func,
   input  logic [LOAD_IDX_W-1:0]      load_index,
   input  logic [VALUE_W-1:0]         load_value,
   input  logic signed [ORIGIN_W-1:0] origin_x,
   input  logic signed [ORIGIN_W-1:0] origin_y,
   input  logic [CELL_W-1:0]          cell_col,
   input  logic [CELL_W-1:0]          cell_row,
   input  logic [SIZE_W-1:0]          sprite_size,
   input  logic [ROT_W-1:0]           rotation,
   output logic                       a_valid,
   output front_type                  a_stage
);

   localparam int STORE_DEPTH = MAX_SPRITE_SIZE * MAX_SPRITE_SIZE;

   logic                 a_valid_ff, a_valid_in;
   front_type            a_ff, a_in;
   logic                 size_ok, cell_ok;
   logic [SRC_IDX_W-1:0] size_w, last_w, col_w, row_w, src_idx;

   always_comb begin
      size_w = SRC_IDX_W'(sprite_size);
      last_w = size_w - SRC_IDX_W'(1);
      col_w  = SRC_IDX_W'(cell_col);
      row_w  = SRC_IDX_W'(cell_row);
      size_ok = (sprite_size != '0) && (7'(sprite_size) <= 7'(MAX_SPRITE_SIZE));
      cell_ok = (SIZE_W'(cell_col) < sprite_size) && (SIZE_W'(cell_row) < sprite_size);

      case (rotation)
         ROT_90:  src_idx = (last_w - col_w) * size_w + row_w;
         ROT_180: src_idx = (last_w - row_w) * size_w + (last_w - col_w);
         ROT_270: src_idx = col_w * size_w + (last_w - row_w);
         default: src_idx = row_w * size_w + col_w;
      endcase

      a_in.draw_ok = (func == FUNC_DRAW) && size_ok && cell_ok;
      a_in.spr_we  = (func == FUNC_LOAD_SPRITE) &&
                     (16'(load_index) < 16'(STORE_DEPTH));
      a_in.pal_we  = (func == FUNC_LOAD_PALETTE) &&
                     (16'(load_index) < 16'(PALETTE_ENTRIES));
      a_in.mem_idx = (func == FUNC_DRAW) ? src_idx : SRC_IDX_W'(load_index);
      a_in.pal_idx = load_index[PAL_IDX_W-1:0];
      a_in.value   = load_value;
      a_in.dx      = {origin_x[ORIGIN_W-1], origin_x} + COORD_W'(cell_col);
      a_in.dy      = {origin_y[ORIGIN_W-1], origin_y} + COORD_W'(cell_row);

      a_valid_in = advance ? in_valid : a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff <= a_in;
      end
   end

   assign a_valid = a_valid_ff;
   assign a_stage = a_ff;

endmodule

FILE: src/rotated_palette_sprite_blit.sv
// Top level of the rotated palette sprite blitter: sprite and palette stores, clipping, output.
//
// Requests arrive on req_tvalid/req_tready with the kind in req_tuser: load a palette
// colour, load a sprite pixel, or draw one sprite cell. Every request gives exactly one
// response on rsp_tvalid/rsp_tready carrying a write enable (rsp_tuser), a framebuffer
// address and a colour; address and colour are zero when no pixel is written.
// Clip edges and byte swap are set through csr_we/csr_index/csr_wdata while idle.
//
// Four register stages: decode and source index, sprite store read plus clip test,
// palette read plus address multiply, output register. One transaction per cycle is
// sustained while rsp_tready is not holding the output; loads and draws may be mixed
// back to back since store writes land in the same stage as the reads.
// A stall on rsp_tready freezes every stage together and drops req_tready, so nothing is
// lost or repeated. Reset empties the pipeline and restores the clip region to the full
// 320x240 screen with no swap; the sprite and palette stores are not cleared and hold
// garbage until loaded.
module rotated_palette_sprite_blit import rpsb_pkg::*; #(
   parameter int SCREEN_WIDTH    = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT   = SCREEN_HEIGHT_DEF,
   parameter int MAX_SPRITE_SIZE = MAX_SPRITE_SIZE_DEF,
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // load_index, load_value, origin_x, origin_y, cell_col, cell_row, sprite_size, rotation
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // func
   input  logic [FUNC_W-1:0]      req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // fb_address, pixel_color
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // write_enable
   output logic                   rsp_tuser,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int STORE_DEPTH = MAX_SPRITE_SIZE * MAX_SPRITE_SIZE;
   localparam int SPR_AW      = $clog2(STORE_DEPTH);
   localparam int PAL_AW      = $clog2(PALETTE_ENTRIES);
   localparam int XW          = $clog2(SCREEN_WIDTH);
   localparam int YW          = $clog2(SCREEN_HEIGHT);
   localparam int FULL_AW     = XW + YW;

   // request fields
   logic [LOAD_IDX_W-1:0]      load_index;
   logic [VALUE_W-1:0]         load_value;
   logic signed [ORIGIN_W-1:0] origin_x, origin_y;
   logic [CELL_W-1:0]          cell_col, cell_row;
   logic [SIZE_W-1:0]          sprite_size;
   logic [ROT_W-1:0]           rotation;

   assign load_index  = req_tdata[9:0];
   assign load_value  = req_tdata[25:10];
   assign origin_x    = req_tdata[41:26];
   assign origin_y    = req_tdata[57:42];
   assign cell_col    = req_tdata[62:58];
   assign cell_row    = req_tdata[67:63];
   assign sprite_size = req_tdata[73:68];
   assign rotation    = req_tdata[75:74];

   // configuration
   logic [8:0] clip_left_ff, clip_right_ff;
   logic [7:0] clip_top_ff, clip_bottom_ff;
   logic       swap_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= CLIP_LEFT_RESET;
         clip_top_ff    <= CLIP_TOP_RESET;
         clip_right_ff  <= CLIP_RIGHT_RESET;
         clip_bottom_ff <= CLIP_BOTTOM_RESET;
         swap_bytes_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CLIP_LEFT:   clip_left_ff   <= csr_wdata;
            CSR_CLIP_TOP:    clip_top_ff    <= csr_wdata[7:0];
            CSR_CLIP_RIGHT:  clip_right_ff  <= csr_wdata;
            CSR_CLIP_BOTTOM: clip_bottom_ff <= csr_wdata[7:0];
            CSR_SWAP_BYTES:  swap_bytes_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves together
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   logic      a_valid;
   front_type a_stage;

   rpsb_front #(
      .MAX_SPRITE_SIZE (MAX_SPRITE_SIZE),
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (adv),
      .in_valid    (req_tvalid),
      .func        (req_tuser),
      .load_index  (load_index),
      .load_value  (load_value),
      .origin_x    (origin_x),
      .origin_y    (origin_y),
      .cell_col    (cell_col),
      .cell_row    (cell_row),
      .sprite_size (sprite_size),
      .rotation    (rotation),
      .a_valid     (a_valid),
      .a_stage     (a_stage)
   );

   // stage B: sprite store, clip test
   logic [PIX_W-1:0]          sprite_ram_ff [STORE_DEPTH];
   logic                      b_valid_ff, b_ok_ff, b_pal_we_ff;
   logic                      b_ok_in, clip_ok;
   logic [PIX_W-1:0]          b_pix_ff;
   logic [PAL_IDX_W-1:0]      b_pal_idx_ff;
   logic [VALUE_W-1:0]        b_value_ff;
   logic signed [COORD_W-1:0] b_dx_ff, b_dy_ff;

   always_comb begin
      clip_ok = (a_stage.dx >= $signed(COORD_W'(clip_left_ff))) &&
                (a_stage.dx <  $signed(COORD_W'(clip_right_ff))) &&
                (a_stage.dy >= $signed(COORD_W'(clip_top_ff))) &&
                (a_stage.dy <  $signed(COORD_W'(clip_bottom_ff))) &&
                (a_stage.dx <  $signed(COORD_W'(SCREEN_WIDTH))) &&
                (a_stage.dy <  $signed(COORD_W'(SCREEN_HEIGHT)));
      b_ok_in = a_stage.draw_ok && clip_ok;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (a_valid && a_stage.spr_we) begin
            sprite_ram_ff[a_stage.mem_idx[SPR_AW-1:0]] <= a_stage.value[PIX_W-1:0];
         end
         b_pix_ff     <= sprite_ram_ff[a_stage.mem_idx[SPR_AW-1:0]];
         b_ok_ff      <= b_ok_in;
         b_pal_we_ff  <= a_stage.pal_we;
         b_pal_idx_ff <= a_stage.pal_idx;
         b_value_ff   <= a_stage.value;
         b_dx_ff      <= a_stage.dx;
         b_dy_ff      <= a_stage.dy;
      end
   end

   // stage C: palette, address multiply
   logic [COLOR_W-1:0]   pal_ram_ff [PALETTE_ENTRIES];
   logic                 c_valid_ff, c_ok_ff, c_ok_in;
   logic [COLOR_W-1:0]   c_color_ff;
   logic [FB_ADDR_W-1:0] c_addr_ff, c_addr_in;
   logic [FULL_AW-1:0]   full_addr;

   always_comb begin
      c_ok_in = b_ok_ff && (b_pix_ff != TRANSPARENT_INDEX) &&
                (9'(b_pix_ff) < 9'(PALETTE_ENTRIES));
      full_addr = FULL_AW'(b_dy_ff[YW-1:0]) * FULL_AW'(SCREEN_WIDTH) +
                  FULL_AW'(b_dx_ff[XW-1:0]);
      c_addr_in = FB_ADDR_W'(full_addr);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (b_valid_ff && b_pal_we_ff) begin
            pal_ram_ff[b_pal_idx_ff[PAL_AW-1:0]] <= b_value_ff;
         end
         c_color_ff <= pal_ram_ff[b_pix_ff[PAL_AW-1:0]];
         c_ok_ff    <= c_ok_in;
         c_addr_ff  <= c_addr_in;
      end
   end

   // stage D: output register
   logic                 rsp_tvalid_ff, rsp_we_ff, rsp_we_in;
   logic [FB_ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [COLOR_W-1:0]   rsp_color_ff, rsp_color_in;

   always_comb begin
      rsp_we_in    = c_valid_ff && c_ok_ff;
      rsp_addr_in  = rsp_we_in ? c_addr_ff : '0;
      rsp_color_in = '0;
      if (rsp_we_in) begin
         rsp_color_in = swap_bytes_ff ?
                        {c_color_ff[BYTE_W-1:0], c_color_ff[COLOR_W-1:BYTE_W]} : c_color_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_we_ff    <= rsp_we_in;
         rsp_addr_ff  <= rsp_addr_in;
         rsp_color_ff <= rsp_color_in;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff    <= 1'b0;
         c_valid_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff    <= a_valid;
         c_valid_ff    <= b_valid_ff;
         rsp_tvalid_ff <= c_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_we_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - FB_ADDR_W - COLOR_W){1'b0}}, rsp_color_ff, rsp_addr_ff};

   // checks
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("response without write carries nonzero payload");

   a_front_moves: assert property (@(posedge clock) disable iff (reset)
      adv && a_valid |=> b_valid_ff)
      else $error("transaction lost between first and second stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv && c_valid_ff |=> c_valid_ff && $stable(c_color_ff) && $stable(c_addr_ff))
      else $error("third stage changed while stalled");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while output stalled");

endmodule
